// File: rtl/metaball_field_evaluator_defines.svh
// Assertion macros shared by the metaball field evaluator RTL
`ifndef METABALL_FIELD_EVALUATOR_DEFINES_SVH
`define METABALL_FIELD_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MFE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfe check failed");

// Next-cycle implication, checked out of reset
`define MFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfe check failed");

`endif

// File: rtl/mfe_pkg.sv
// Shared types and constants for the metaball field evaluator
package mfe_pkg;

	localparam int MAX_BALLS_DEF  = 4;
	localparam int POS_WIDTH_DEF  = 16;
	localparam int R2_WIDTH       = 16;
	localparam int CNT_WIDTH      = 3;
	localparam int OUT_WIDTH      = 32;
	localparam int CNT_EXT_WIDTH  = 5;
	localparam int VAL_SHIFT      = 24;
	localparam int NRM_SHIFT      = 32;
	localparam logic [CNT_WIDTH-1:0] BALL_COUNT_RST = 3'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQ,
		ST_SUM,
		ST_MUL,
		ST_DSTART,
		ST_DIV,
		ST_ACC,
		ST_DONE
	} mfe_state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic load;
		logic start;
		logic diff;
		logic sq;
		logic sum;
		logic mul;
		logic dstart;
		logic dstep;
		logic acc;
		logic finish;
	} mfe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_eval;
		logic count_zero;
		logic last_ball;
		logic out_free;
	} mfe_status_t;

endpackage

// File: rtl/mfe_in_if.sv
// Input channel: load and evaluate words
interface mfe_in_if #(parameter int PW = 16) ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [1:0]          ball_index;
	logic signed [PW-1:0] ball_x;
	logic signed [PW-1:0] ball_y;
	logic signed [PW-1:0] ball_z;
	logic [15:0]         ball_sq_radius;
	logic signed [PW-1:0] vertex_x;
	logic signed [PW-1:0] vertex_y;
	logic signed [PW-1:0] vertex_z;

	modport source (output valid, operation, ball_index, ball_x, ball_y, ball_z,
		ball_sq_radius, vertex_x, vertex_y, vertex_z, input ready);
	modport sink (input valid, operation, ball_index, ball_x, ball_y, ball_z,
		ball_sq_radius, vertex_x, vertex_y, vertex_z, output ready);
endinterface

// File: rtl/mfe_out_if.sv
// Output channel: field value and normal words
interface mfe_out_if ();
	logic               valid;
	logic               ready;
	logic [31:0]        field_value;
	logic signed [31:0] normal_x;
	logic signed [31:0] normal_y;
	logic signed [31:0] normal_z;
	logic               clipped;

	modport source (output valid, field_value, normal_x, normal_y, normal_z, clipped,
		input ready);
	modport sink (input valid, field_value, normal_x, normal_y, normal_z, clipped,
		output ready);
endinterface

// File: rtl/mfe_div.sv
// Restoring divider, one quotient bit per step
module mfe_div #(
	parameter int NW = 64,
	parameter int DW = 68
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);
	logic [DW-1:0] rem_q;
	logic [NW-1:0] sh_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   sub;
	logic          ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, sh_q[NW-1]};
		sub   = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			sh_q  <= num;
			quo_q <= '0;
			den_q <= den;
		end else if (step) begin
			rem_q <= ge ? sub[DW-1:0] : trial[DW-1:0];
			sh_q  <= {sh_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign quo = quo_q;
endmodule

// File: rtl/mfe_ctrl.sv
// Sequencer for loads and per-ball evaluation steps
module mfe_ctrl import mfe_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mfe_status_t sts,
	output mfe_cmd_t    cmd
);
	localparam int ITER = POS_WIDTH + R2_WIDTH + 1 + NRM_SHIFT;
	localparam int ITW  = $clog2(ITER + 1);

	mfe_state_t state_q, state_d;
	logic [ITW-1:0] iter_q, iter_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					if (sts.in_eval) begin
						cmd.start = 1'b1;
						state_d   = sts.count_zero ? ST_DONE : ST_DIFF;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.dstart = 1'b1;
				iter_d     = ITW'(ITER);
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.dstep = 1'b1;
				iter_d    = iter_q - 1'b1;
				if (iter_q == ITW'(1))
					state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last_ball ? ST_DONE : ST_DIFF;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: rtl/mfe_datapath.sv
// Ball table, distance and divide datapath, accumulators and output register
module mfe_datapath import mfe_pkg::*; #(
	parameter int MAX_BALLS = MAX_BALLS_DEF,
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CNT_WIDTH-1:0] cfg_wdata,
	mfe_in_if.sink               in_ch,
	mfe_out_if.source            out_ch,
	input  mfe_cmd_t             cmd,
	output mfe_status_t          sts
);
	localparam int PW   = POS_WIDTH;
	localparam int IDXW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
	localparam int AW   = PW + 1;
	localparam int D2W  = 2 * PW + 2;
	localparam int DDW  = 2 * D2W;
	localparam int NPW  = R2_WIDTH + AW;
	localparam int NNW  = NPW + NRM_SHIFT;
	localparam int LGB  = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
	localparam int VAW  = OUT_WIDTH + LGB + 1;
	localparam int SAW  = OUT_WIDTH + LGB + 2;
	localparam logic [CNT_EXT_WIDTH-1:0] MAXB = CNT_EXT_WIDTH'(MAX_BALLS);
	localparam logic signed [SAW-1:0] SMAX = {{(SAW-32){1'b0}}, 32'h7FFF_FFFF};
	localparam logic signed [SAW-1:0] SMIN = {{(SAW-32){1'b1}}, 32'h8000_0000};

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [PW-1:0] z;
		logic [R2_WIDTH-1:0]  r2;
	} ball_t;

	ball_t                ball_q [MAX_BALLS];
	logic [CNT_WIDTH-1:0] ball_count_q;
	logic [IDXW-1:0]      idx_q;
	logic signed [PW-1:0] vx_q, vy_q, vz_q;
	logic [CNT_EXT_WIDTH-1:0] cnt_eff, idx_ext, wa_ext;
	ball_t                cur;

	// distance pipeline registers
	logic [AW-1:0]       ax_s1, ay_s1, az_s1;
	logic                nx_s1, ny_s1, nz_s1;
	logic [R2_WIDTH-1:0] r2_s1;
	logic [D2W-1:0]      sqx_s2, sqy_s2, sqz_s2;
	logic [NPW-1:0]      npx_s2, npy_s2, npz_s2;
	logic [R2_WIDTH-1:0] r2_s2;
	logic [D2W-1:0]      d2_s3;
	logic [DDW-1:0]      dd_s4;
	logic signed [AW-1:0] dx, dy, dz;
	logic [D2W-1:0]      d2_sum;

	logic [NNW-1:0] qv, qx, qy, qz;
	logic [VAW-1:0]        val_q;
	logic signed [SAW-1:0] sx_q, sy_q, sz_q;
	logic                  clip_q;
	logic [33:0]           tx, ty, tz;
	logic                  vclip;
	logic [OUT_WIDTH-1:0]  vterm;

	logic                  out_valid_q;
	logic [OUT_WIDTH-1:0]  fv_q;
	logic signed [31:0]    ox_q, oy_q, oz_q;
	logic                  oc_q;
	logic [OUT_WIDTH-1:0]  fv_d;
	logic signed [31:0]    ox_d, oy_d, oz_d;
	logic                  oc_d;

	// clamp a normal quotient to the signed 32-bit range; returns {clip, term}
	function automatic logic [33:0] nterm(input logic [NNW-1:0] q, input logic neg);
		logic                clp;
		logic signed [32:0]  t;
		if (neg) begin
			clp = (|q[NNW-1:32]) || (q[31] && (|q[30:0]));
			t   = clp ? -33'sh0_8000_0000 : -$signed({1'b0, q[31:0]});
		end else begin
			clp = |q[NNW-1:31];
			t   = clp ? 33'sh0_7FFF_FFFF : $signed({2'b00, q[30:0]});
		end
		return {clp, t};
	endfunction

	// clamp a signed sum to 32 bits; returns {clip, value}
	function automatic logic [32:0] sclamp(input logic signed [SAW-1:0] s);
		if (s > SMAX)
			return {1'b1, 32'h7FFF_FFFF};
		if (s < SMIN)
			return {1'b1, 32'h8000_0000};
		return {1'b0, s[31:0]};
	endfunction

	// count and index bookkeeping
	assign cnt_eff = ({2'b00, ball_count_q} > MAXB) ? MAXB : {2'b00, ball_count_q};
	assign idx_ext = {{(CNT_EXT_WIDTH-IDXW){1'b0}}, idx_q};
	assign wa_ext  = {3'b000, in_ch.ball_index};
	assign cur     = ball_q[idx_q];

	assign sts.in_valid   = in_ch.valid;
	assign sts.in_eval    = in_ch.operation == OP_EVAL;
	assign sts.count_zero = cnt_eff == '0;
	assign sts.last_ball  = (idx_ext + 1'b1) == cnt_eff;
	assign sts.out_free   = !out_valid_q || out_ch.ready;
	assign in_ch.ready    = cmd.in_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ball_count_q <= BALL_COUNT_RST;
		else if (cfg_we)
			ball_count_q <= cfg_wdata;
	end

	// ball table
	always_ff @(posedge clk) begin
		if (cmd.load && (wa_ext < MAXB))
			ball_q[wa_ext[IDXW-1:0]] <= {in_ch.ball_x, in_ch.ball_y, in_ch.ball_z,
				in_ch.ball_sq_radius};
	end

	// ball index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (cmd.start)
			idx_q <= '0;
		else if (cmd.acc)
			idx_q <= idx_q + 1'b1;
	end

	// vertex minus centre
	always_comb begin
		dx     = $signed({vx_q[PW-1], vx_q}) - $signed({cur.x[PW-1], cur.x});
		dy     = $signed({vy_q[PW-1], vy_q}) - $signed({cur.y[PW-1], cur.y});
		dz     = $signed({vz_q[PW-1], vz_q}) - $signed({cur.z[PW-1], cur.z});
		d2_sum = sqx_s2 + sqy_s2 + sqz_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vx_q <= in_ch.vertex_x;
			vy_q <= in_ch.vertex_y;
			vz_q <= in_ch.vertex_z;
		end
		if (cmd.diff) begin
			ax_s1 <= dx[AW-1] ? AW'(-dx) : AW'(dx);
			ay_s1 <= dy[AW-1] ? AW'(-dy) : AW'(dy);
			az_s1 <= dz[AW-1] ? AW'(-dz) : AW'(dz);
			nx_s1 <= dx[AW-1];
			ny_s1 <= dy[AW-1];
			nz_s1 <= dz[AW-1];
			r2_s1 <= cur.r2;
		end
		if (cmd.sq) begin
			sqx_s2 <= D2W'(ax_s1 * ax_s1);
			sqy_s2 <= D2W'(ay_s1 * ay_s1);
			sqz_s2 <= D2W'(az_s1 * az_s1);
			npx_s2 <= NPW'(r2_s1 * ax_s1);
			npy_s2 <= NPW'(r2_s1 * ay_s1);
			npz_s2 <= NPW'(r2_s1 * az_s1);
			r2_s2  <= r2_s1;
		end
		// zero distance becomes one LSB
		if (cmd.sum)
			d2_s3 <= (d2_sum == '0) ? D2W'(1) : d2_sum;
		if (cmd.mul)
			dd_s4 <= DDW'(d2_s3 * d2_s3);
	end

	// four dividers share the step command
	mfe_div #(.NW(NNW), .DW(D2W)) u_div_v (
		.clk(clk), .load(cmd.dstart), .step(cmd.dstep),
		.num({{(NNW-R2_WIDTH-VAL_SHIFT){1'b0}}, r2_s2, {VAL_SHIFT{1'b0}}}),
		.den(d2_s3), .quo(qv));
	mfe_div #(.NW(NNW), .DW(DDW)) u_div_x (
		.clk(clk), .load(cmd.dstart), .step(cmd.dstep),
		.num({npx_s2, {NRM_SHIFT{1'b0}}}), .den(dd_s4), .quo(qx));
	mfe_div #(.NW(NNW), .DW(DDW)) u_div_y (
		.clk(clk), .load(cmd.dstart), .step(cmd.dstep),
		.num({npy_s2, {NRM_SHIFT{1'b0}}}), .den(dd_s4), .quo(qy));
	mfe_div #(.NW(NNW), .DW(DDW)) u_div_z (
		.clk(clk), .load(cmd.dstart), .step(cmd.dstep),
		.num({npz_s2, {NRM_SHIFT{1'b0}}}), .den(dd_s4), .quo(qz));

	// per-ball term saturation
	always_comb begin
		vclip = |qv[NNW-1:OUT_WIDTH];
		vterm = vclip ? '1 : qv[OUT_WIDTH-1:0];
		tx    = nterm(qx, nx_s1);
		ty    = nterm(qy, ny_s1);
		tz    = nterm(qz, nz_s1);
	end

	// accumulators
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q  <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			sz_q   <= '0;
			clip_q <= 1'b0;
		end else if (cmd.acc) begin
			val_q  <= val_q + {{(VAW-OUT_WIDTH){1'b0}}, vterm};
			sx_q   <= sx_q + SAW'($signed(tx[32:0]));
			sy_q   <= sy_q + SAW'($signed(ty[32:0]));
			sz_q   <= sz_q + SAW'($signed(tz[32:0]));
			clip_q <= clip_q | vclip | tx[33] | ty[33] | tz[33];
		end
	end

	// final sum saturation
	always_comb begin
		logic [32:0] cx, cy, cz;
		logic        vs;
		cx   = sclamp(sx_q);
		cy   = sclamp(sy_q);
		cz   = sclamp(sz_q);
		vs   = |val_q[VAW-1:OUT_WIDTH];
		fv_d = vs ? '1 : val_q[OUT_WIDTH-1:0];
		ox_d = $signed(cx[31:0]);
		oy_d = $signed(cy[31:0]);
		oz_d = $signed(cz[31:0]);
		oc_d = clip_q | vs | cx[32] | cy[32] | cz[32];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			fv_q <= fv_d;
			ox_q <= ox_d;
			oy_q <= oy_d;
			oz_q <= oz_d;
			oc_q <= oc_d;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.field_value = fv_q;
	assign out_ch.normal_x    = ox_q;
	assign out_ch.normal_y    = oy_q;
	assign out_ch.normal_z    = oz_q;
	assign out_ch.clipped     = oc_q;
endmodule

// File: rtl/metaball_field_evaluator.sv
// Metaball field evaluator top level: controller, datapath and checks
// Usage:
//  in_ch carries load and evaluate words under valid/ready. A load word
//  (operation 0) writes table entry ball_index; indexes at or above
//  MAX_BALLS are dropped. An evaluate word (operation 1) sums the active
//  balls and returns one word on out_ch: field value, normal, clip.
//  cfg_we/cfg_wdata write ball_count; write it only while the block is idle.
//  Sequence: each ball steps through the DIFF, SQ, SUM, MUL, DSTART, DIV
//  and ACC states; in DIV the restoring dividers that form the value and
//  the three normal quotients together produce one quotient bit per cycle.
//  A load word leaves the block idle and ready for the next word.
//  One word is worked on at a time; the next word is accepted as soon as
//  the result sits in the output register.
//  Stall: while out_ch.ready is low the result holds, and a finished second
//  evaluation waits until the register frees up.
//  Reset: ball_count returns to 3, the output goes empty; table contents
//  stay undefined until loaded.
`include "metaball_field_evaluator_defines.svh"
module metaball_field_evaluator import mfe_pkg::*; #(
	parameter int MAX_BALLS = MAX_BALLS_DEF,
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CNT_WIDTH-1:0] cfg_wdata,
	mfe_in_if.sink               in_ch,
	mfe_out_if.source            out_ch
);
	mfe_cmd_t    cmd;
	mfe_status_t sts;

	mfe_ctrl #(.POS_WIDTH(POS_WIDTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd));

	mfe_datapath #(.MAX_BALLS(MAX_BALLS), .POS_WIDTH(POS_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .sts(sts));

	// an accepted evaluation keeps the input closed next cycle
	`MFE_ASSERT_NEXT(a_eval_busy, in_ch.valid && in_ch.ready && in_ch.operation == OP_EVAL,
		!in_ch.ready)
	// dividers never step while the input is open
	`MFE_ASSERT_NOW(a_step_closed, cmd.dstep, !in_ch.ready)
	// a result is only loaded when the output register is free
	`MFE_ASSERT_NOW(a_finish_free, cmd.finish, !out_ch.valid || out_ch.ready)
endmodule
